@@ sv/mwm_pkg.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Widths, register codes and the word types passed between the mixer's front
// end, its queue and its back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

  localparam int unsigned LANES      = 4;   // front A, front B, rear A, rear B
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned LEVER_W    = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned LIMIT_W    = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // wheel speed in Q.16, command in Q.24
  localparam int unsigned SPEED_W  = 27;
  localparam int unsigned CMD_W    = SPEED_W + GAIN_W;
  localparam int unsigned MAG_W    = CMD_W - 1;
  localparam int unsigned LIM_SHIFT = 16;

  // scaling: (magnitude * limit) / top, quotient never above the limit
  localparam int unsigned HALF_W = MAG_W / 2;
  localparam int unsigned PROD_W = HALF_W + LIMIT_W;
  localparam int unsigned DIVD_W = MAG_W + LIMIT_W;
  localparam int unsigned QUO_W  = LIMIT_W;

  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);

  // lanes whose command leaves negated
  localparam logic [LANES-1:0] LANE_IS_A = 4'b0101;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVER = 2'd0,
    REG_GAIN  = 2'd1,
    REG_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [LEVER_W-1:0] lever;
    logic [GAIN_W-1:0]  gain;
    logic [LIMIT_W-1:0] limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    lever: LEVER_W'(261),
    gain:  GAIN_W'(18358),
    limit: LIMIT_W'(8960)
  };

  // one classified command, front end to back end
  typedef struct packed {
    logic                         scaled;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][MAG_W-1:0]  mag;
    logic [MAG_W-1:0]             top;
  } job_t;

  // data riding alongside the divider
  typedef struct packed {
    logic                         scaled;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][QUO_W-1:0]  plain;
  } side_t;

endpackage

`default_nettype wire

@@ sv/mwm_cfg.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer configuration registers
// Holds the rotation lever, speed gain and command limit; writes to an
// unknown index are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_cfg
  import mwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LEVER: cfg_r.lever <= cfg_wdata[LEVER_W-1:0];
        REG_GAIN:  cfg_r.gain  <= cfg_wdata[GAIN_W-1:0];
        REG_LIMIT: cfg_r.limit <= cfg_wdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/mwm_front.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer front end
// Accepts velocity commands, forms the four wheel commands, their magnitudes
// and the largest one, and decides whether the set must be scaled.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_front
  import mwm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_linear_x,
  input  logic signed [DATA_W-1:0] in_linear_y,
  input  logic signed [DATA_W-1:0] in_angular_z,
  input  logic                     q_full,
  output logic                     q_push,
  output job_t                     q_word
);

  logic [FRONT_STAGES-1:0] fv_r;
  logic                    adv;

  logic signed [SPEED_W-1:0] x_r, y_r, kw_r;
  logic signed [SPEED_W-1:0] x_nxt, y_nxt, kw_nxt;
  logic signed [SPEED_W-1:0] sp_r  [LANES];
  logic signed [CMD_W-1:0]   cmd_r [LANES];
  logic [LANES-1:0][MAG_W-1:0] mag4_r, mag4_nxt, mag5_r;
  logic [LANES-1:0]            neg4_r, neg4_nxt, neg5_r;
  logic [MAG_W-1:0]            max01_r, max23_r, top_nxt;
  job_t                        job_r;

  // hold everything while the last word waits for room in the queue
  assign adv      = !(fv_r[FRONT_STAGES-1] && q_full);
  assign in_stall = !adv;
  assign q_push   = fv_r[FRONT_STAGES-1] && !q_full;
  assign q_word   = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (adv) begin
      fv_r <= {fv_r[FRONT_STAGES-2:0], in_valid};
    end
  end

  // stage 1: operands in Q.16
  always_comb begin
    x_nxt  = {{(SPEED_W-DATA_W-FRAC_W){in_linear_x[DATA_W-1]}}, in_linear_x,
              {FRAC_W{1'b0}}};
    y_nxt  = {{(SPEED_W-DATA_W-FRAC_W){in_linear_y[DATA_W-1]}}, in_linear_y,
              {FRAC_W{1'b0}}};
    kw_nxt = SPEED_W'($signed({1'b0, cfg.lever})) * SPEED_W'(in_angular_z);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r  <= x_nxt;
      y_r  <= y_nxt;
      kw_r <= kw_nxt;
    end
  end

  // stage 2: wheel speeds
  always_ff @(posedge clk) begin
    if (adv) begin
      sp_r[0] <= x_r + y_r + kw_r;
      sp_r[1] <= x_r - y_r - kw_r;
      sp_r[2] <= x_r - y_r + kw_r;
      sp_r[3] <= x_r + y_r - kw_r;
    end
  end

  // stage 3: commands in Q.24
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        cmd_r[i] <= CMD_W'(sp_r[i]) * CMD_W'($signed({1'b0, cfg.gain}));
      end
    end
  end

  // stage 4: sign and magnitude; fold the output negation of the A wheels in
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      neg4_nxt[i] = cmd_r[i][CMD_W-1] ^ LANE_IS_A[i];
      mag4_nxt[i] = cmd_r[i][CMD_W-1] ? MAG_W'(-cmd_r[i]) : MAG_W'(cmd_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag4_r <= mag4_nxt;
      neg4_r <= neg4_nxt;
    end
  end

  // stage 5: pairwise maxima
  always_ff @(posedge clk) begin
    if (adv) begin
      mag5_r  <= mag4_r;
      neg5_r  <= neg4_r;
      max01_r <= (mag4_r[0] > mag4_r[1]) ? mag4_r[0] : mag4_r[1];
      max23_r <= (mag4_r[2] > mag4_r[3]) ? mag4_r[2] : mag4_r[3];
    end
  end

  // stage 6: largest magnitude against the limit
  assign top_nxt = (max01_r > max23_r) ? max01_r : max23_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      job_r.mag    <= mag5_r;
      job_r.neg    <= neg5_r;
      job_r.top    <= top_nxt;
      job_r.scaled <= top_nxt > MAG_W'({cfg.limit, {LIM_SHIFT{1'b0}}});
    end
  end

endmodule

`default_nettype wire

@@ sv/mwm_fifo.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer queue
// Short first-in first-out buffer of classified words between the front and
// back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_fifo
  import mwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_word,
  input  logic pop,
  output job_t pop_word,
  output logic full,
  output logic not_empty
);

  job_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_word  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

@@ sv/mwm_back.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer back end
// Scales the four magnitudes by limit / top through a pipelined restoring
// divider, one quotient bit a stage, then applies signs into the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_back
  import mwm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [LIMIT_W-1:0]       limit,
  input  logic                     q_ready,
  input  job_t                     q_word,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_front_a_command,
  output logic signed [DATA_W-1:0] out_front_b_command,
  output logic signed [DATA_W-1:0] out_rear_a_command,
  output logic signed [DATA_W-1:0] out_rear_b_command,
  output logic                     out_was_scaled
);

  logic adv;

  logic                          b1_v_r;
  logic [LANES-1:0][PROD_W-1:0]  phi_r, plo_r;
  logic [MAG_W-1:0]              b1_top_r;
  side_t                         b1_side_r;

  // position k holds the remainder before quotient bit QUO_W-1-k is decided
  logic [QUO_W:0]                dv_r;
  logic [LANES-1:0][DIVD_W-1:0]  rem_r  [QUO_W];
  logic [MAG_W-1:0]              dtop_r [QUO_W];
  logic [LANES-1:0][QUO_W-1:0]   quo_r  [QUO_W+1];
  side_t                         dside_r [QUO_W+1];

  logic                          out_valid_r;
  logic [LANES-1:0][DATA_W-1:0]  res_r, res_nxt;
  logic                          scaled_r;

  // hold the whole pipe while the output word is stalled
  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r      <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b1_v_r      <= q_ready;
      dv_r        <= {dv_r[QUO_W-1:0], b1_v_r};
      out_valid_r <= dv_r[QUO_W];
    end
  end

  // partial products of magnitude times limit
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        phi_r[i]             <= PROD_W'(q_word.mag[i][MAG_W-1:HALF_W]) * PROD_W'(limit);
        plo_r[i]             <= PROD_W'(q_word.mag[i][HALF_W-1:0]) * PROD_W'(limit);
        b1_side_r.plain[i]   <= q_word.mag[i][LIM_SHIFT +: QUO_W];
      end
      b1_side_r.neg    <= q_word.neg;
      b1_side_r.scaled <= q_word.scaled;
      b1_top_r         <= q_word.top;
    end
  end

  // full dividend
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        rem_r[0][i] <= (DIVD_W'(phi_r[i]) << HALF_W) + DIVD_W'(plo_r[i]);
      end
      quo_r[0]   <= '0;
      dtop_r[0]  <= b1_top_r;
      dside_r[0] <= b1_side_r;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int unsigned SH = QUO_W - 1 - k;

    logic [DIVD_W-1:0]             dsr;
    logic [LANES-1:0][DIVD_W-1:0]  rem_nxt;
    logic [LANES-1:0][QUO_W-1:0]   quo_nxt;

    assign dsr = DIVD_W'(dtop_r[k]) << SH;

    always_comb begin
      rem_nxt = rem_r[k];
      quo_nxt = quo_r[k];
      for (int i = 0; i < LANES; i++) begin
        if (rem_r[k][i] >= dsr) begin
          rem_nxt[i]     = rem_r[k][i] - dsr;
          quo_nxt[i][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[k+1]   <= quo_nxt;
        dside_r[k+1] <= dside_r[k];
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k+1]  <= rem_nxt;
          dtop_r[k+1] <= dtop_r[k];
        end
      end
    end
  end

  // pick scaled or plain magnitude, then apply the sign
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (dside_r[QUO_W].scaled) begin
        res_nxt[i] = DATA_W'(quo_r[QUO_W][i]);
      end else begin
        res_nxt[i] = DATA_W'(dside_r[QUO_W].plain[i]);
      end
      if (dside_r[QUO_W].neg[i]) begin
        res_nxt[i] = -res_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r    <= res_nxt;
      scaled_r <= dside_r[QUO_W].scaled;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_front_a_command = $signed(res_r[0]);
  assign out_front_b_command = $signed(res_r[1]);
  assign out_rear_a_command  = $signed(res_r[2]);
  assign out_rear_b_command  = $signed(res_r[3]);
  assign out_was_scaled      = scaled_r;

endmodule

`default_nettype wire

@@ sv/mecanum_wheel_mixer.sv @@
// ----------------------------------------------------------------------------
// Mecanum wheel mixer
// Turns a body velocity command into four mecanum wheel commands, scaled down
// together when any of them exceeds the command limit.
//
// Input channel (in_valid / in_stall): one word of linear_x, linear_y and
// angular_z, all signed Q8.8. Result channel (out_valid / out_stall): the four
// wheel commands, A wheels negated, and a flag set when scaling took place.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_wdata): 0 rotation
// lever, 1 speed gain, 2 command limit; other indexes are ignored. cfg_ready
// is always high; write only while the block is empty.
// One word is taken every cycle unless in_stall is high. The front end (6
// stages) and the back end (product, dividend, 15 divider stages and the
// output register) are joined by a four-word queue, so the input keeps
// flowing while a result is stalled until the queue and the front stages
// fill up; a stalled result simply holds.
// Reset clears all words in flight and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module mecanum_wheel_mixer
  import mwm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_linear_x,
  input  logic signed [DATA_W-1:0] in_linear_y,
  input  logic signed [DATA_W-1:0] in_angular_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_front_a_command,
  output logic signed [DATA_W-1:0] out_front_b_command,
  output logic signed [DATA_W-1:0] out_rear_a_command,
  output logic signed [DATA_W-1:0] out_rear_b_command,
  output logic                     out_was_scaled,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  cfg_t cfg;
  logic q_full, q_push, q_pop, q_not_empty;
  job_t q_push_word, q_pop_word;

  mwm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mwm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_linear_x  (in_linear_x),
    .in_linear_y  (in_linear_y),
    .in_angular_z (in_angular_z),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_word       (q_push_word)
  );

  mwm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_push_word),
    .pop       (q_pop),
    .pop_word  (q_pop_word),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  mwm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .limit               (cfg.limit),
    .q_ready             (q_not_empty),
    .q_word              (q_pop_word),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_front_a_command (out_front_a_command),
    .out_front_b_command (out_front_b_command),
    .out_rear_a_command  (out_rear_a_command),
    .out_rear_b_command  (out_rear_b_command),
    .out_was_scaled      (out_was_scaled)
  );

endmodule

`default_nettype wire

@@ test/mwm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer checker
// Follows the register writes, works out the four wheel commands and the
// scaling flag for every accepted command word, and checks the result words
// against them in order.
// ----------------------------------------------------------------------------

module mwm_checker
  import mwm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] in_linear_x,
  input  logic signed [DATA_W-1:0] in_linear_y,
  input  logic signed [DATA_W-1:0] in_angular_z,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_front_a_command,
  input  logic signed [DATA_W-1:0] out_front_b_command,
  input  logic signed [DATA_W-1:0] out_rear_a_command,
  input  logic signed [DATA_W-1:0] out_rear_b_command,
  input  logic                     out_was_scaled,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  output int                       mismatches,
  output int                       pending,
  output int                       checked,
  output int                       scaled_seen
);

  typedef struct packed {
    logic signed [DATA_W-1:0] front_a;
    logic signed [DATA_W-1:0] front_b;
    logic signed [DATA_W-1:0] rear_a;
    logic signed [DATA_W-1:0] rear_b;
    logic                     scaled;
  } wheel_word_t;

  logic [LEVER_W-1:0] lever_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LIMIT_W-1:0] limit_q;
  wheel_word_t        wheel_queue [$];

  // Wheel speeds in Q.16, commands in Q.24; everything exact until the final
  // truncation toward zero.
  function automatic wheel_word_t mix_wheels(input logic signed [DATA_W-1:0] vx,
                                             input logic signed [DATA_W-1:0] vy,
                                             input logic signed [DATA_W-1:0] wz);
    longint      fwd;
    longint      side;
    longint      turn;
    longint      gain;
    longint      lim;
    longint      top_mag;
    longint      mag;
    longint      cmd [LANES];
    longint      res [LANES];
    wheel_word_t w;
    int          i;
    fwd  = longint'(vx) * 256;
    side = longint'(vy) * 256;
    turn = longint'(lever_q) * longint'(wz);
    gain = longint'(gain_q);
    lim  = longint'(limit_q);
    // lane order: front A, front B, rear A, rear B
    cmd[0] = (fwd + side + turn) * gain;
    cmd[1] = (fwd - side - turn) * gain;
    cmd[2] = (fwd - side + turn) * gain;
    cmd[3] = (fwd + side - turn) * gain;
    top_mag = 0;
    for (i = 0; i < LANES; i++) begin
      mag = (cmd[i] < 0) ? -cmd[i] : cmd[i];
      if (mag > top_mag) begin
        top_mag = mag;
      end
    end
    // equal to the limit passes untouched
    w.scaled = (top_mag > lim * 65536);
    for (i = 0; i < LANES; i++) begin
      if (w.scaled) begin
        res[i] = (cmd[i] * lim) / top_mag;
      end else begin
        res[i] = cmd[i] / 65536;
      end
    end
    w.front_a = DATA_W'(-res[0]);
    w.front_b = DATA_W'(res[1]);
    w.rear_a  = DATA_W'(-res[2]);
    w.rear_b  = DATA_W'(res[3]);
    return w;
  endfunction

  always @(posedge clk) begin
    wheel_word_t want;
    wheel_word_t got;
    if (!rst_n) begin
      lever_q = CFG_RESET.lever;
      gain_q  = CFG_RESET.gain;
      limit_q = CFG_RESET.limit;
      wheel_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LEVER: lever_q = LEVER_W'(cfg_wdata);
          REG_GAIN:  gain_q  = GAIN_W'(cfg_wdata);
          REG_LIMIT: limit_q = LIMIT_W'(cfg_wdata);
          default: ;  // drop writes to unused indexes
        endcase
      end
      if (in_valid && !in_stall) begin
        wheel_queue.push_back(mix_wheels(in_linear_x, in_linear_y, in_angular_z));
      end
      if (out_valid && !out_stall) begin
        got = '{front_a: out_front_a_command, front_b: out_front_b_command,
                rear_a: out_rear_a_command, rear_b: out_rear_b_command,
                scaled: out_was_scaled};
        if (wheel_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result word with nothing outstanding", $realtime);
          end
        end else begin
          want = wheel_queue.pop_front();
          checked++;
          if (want.scaled) begin
            scaled_seen++;
          end
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: word %0d expected fa=%0d fb=%0d ra=%0d rb=%0d sc=%0b",
                       $realtime, checked, $signed(want.front_a),
                       $signed(want.front_b), $signed(want.rear_a),
                       $signed(want.rear_b), want.scaled);
              $display("%0t: word %0d actual   fa=%0d fb=%0d ra=%0d rb=%0d sc=%0b",
                       $realtime, checked, $signed(got.front_a),
                       $signed(got.front_b), $signed(got.rear_a),
                       $signed(got.rear_b), got.scaled);
            end
          end
        end
      end
    end
    pending = wheel_queue.size();
  end

endmodule

@@ test/tb_mecanum_wheel_mixer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer testbench
// Drives directed corner commands and randomised command words through the
// mixer under a range of lever, gain and limit settings, with random gaps and
// result stalls; the checker beside the block scores every result word.
// ----------------------------------------------------------------------------

module tb_mecanum_wheel_mixer;
  import mwm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_PHASES   = 6;
  localparam int WORDS_PER_PHASE = 300;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_linear_x;
  logic signed [DATA_W-1:0] in_linear_y;
  logic signed [DATA_W-1:0] in_angular_z;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_front_a_command;
  logic signed [DATA_W-1:0] out_front_b_command;
  logic signed [DATA_W-1:0] out_rear_a_command;
  logic signed [DATA_W-1:0] out_rear_b_command;
  logic                     out_was_scaled;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;

  int mismatches;
  int pending;
  int checked;
  int scaled_seen;
  int sent;
  int settings;
  int stuck_cycles;
  bit quiet;

  mecanum_wheel_mixer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_linear_x         (in_linear_x),
    .in_linear_y         (in_linear_y),
    .in_angular_z        (in_angular_z),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_front_a_command (out_front_a_command),
    .out_front_b_command (out_front_b_command),
    .out_rear_a_command  (out_rear_a_command),
    .out_rear_b_command  (out_rear_b_command),
    .out_was_scaled      (out_was_scaled),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  mwm_checker u_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_linear_x         (in_linear_x),
    .in_linear_y         (in_linear_y),
    .in_angular_z        (in_angular_z),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_front_a_command (out_front_a_command),
    .out_front_b_command (out_front_b_command),
    .out_rear_a_command  (out_rear_a_command),
    .out_rear_b_command  (out_rear_b_command),
    .out_was_scaled      (out_was_scaled),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .mismatches          (mismatches),
    .pending             (pending),
    .checked             (checked),
    .scaled_seen         (scaled_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: stall in bursts, none once the run goes quiet.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Abort when no word moves on any channel for too long.
  initial begin
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("Watchdog: %0d idle cycles, %0d results outstanding", stuck_cycles, pending);
    $display("DONE: errors detected");
    $finish;
  end

  // Hold the word until it is taken, then advance to the next falling edge.
  task automatic push_command(input logic signed [DATA_W-1:0] vx,
                              input logic signed [DATA_W-1:0] vy,
                              input logic signed [DATA_W-1:0] wz);
    in_valid     = 1'b1;
    in_linear_x  = vx;
    in_linear_y  = vy;
    in_angular_z = wz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only with the pipe empty.
  task automatic apply_settings(input logic [CFG_DATA_W-1:0] lever,
                                input logic [CFG_DATA_W-1:0] gain,
                                input logic [CFG_DATA_W-1:0] limit,
                                input bit                    spare);
    drain();
    write_reg(REG_LEVER, lever);
    write_reg(REG_GAIN, gain);
    write_reg(REG_LIMIT, limit);
    if (spare) begin
      write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    end
    cfg_valid = 1'b0;
    settings++;
  endtask

  // Mix of corners, small values and full range.
  function automatic logic signed [DATA_W-1:0] pick_speed();
    int v;
    case ($urandom_range(0, 6))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -32768;
          1: v = 32767;
          2: v = -1;
          3: v = 1;
          default: v = 0;
        endcase
      end
      1, 2: v = int'($urandom_range(0, 255)) - 128;
      3: v = int'($urandom_range(0, 4095)) - 2048;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return DATA_W'(v);
  endfunction

  initial begin
    int                    ph;
    int                    n;
    logic [CFG_DATA_W-1:0] lv;
    logic [CFG_DATA_W-1:0] gn;
    logic [CFG_DATA_W-1:0] lm;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_linear_x  = '0;
    in_linear_y  = '0;
    in_angular_z = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_LEVER;
    cfg_wdata    = '0;
    quiet        = 1'b0;
    sent         = 0;
    settings     = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // register values straight out of reset
    push_command(16'sd0, 16'sd0, 16'sd0);
    push_command(16'sd32767, 16'sd32767, 16'sd32767);
    push_command(-16'sd32768, -16'sd32768, -16'sd32768);
    push_command(16'sd32767, -16'sd32768, 16'sd0);
    push_command(-16'sd32768, 16'sd32767, 16'sd32767);
    push_command(16'sd1, 16'sd0, 16'sd0);
    push_command(16'sd0, -16'sd1, 16'sd0);
    push_command(16'sd0, 16'sd0, 16'sd1);
    push_command(16'sd20, -16'sd15, 16'sd8);

    // unit gain, no lever: magnitude equal to the limit stays unscaled
    apply_settings(16'd0, 16'd256, 16'd1000, 1'b0);
    push_command(16'sd1000, 16'sd0, 16'sd0);
    push_command(16'sd1001, 16'sd0, 16'sd0);
    push_command(-16'sd1000, 16'sd0, 16'sd0);
    push_command(-16'sd1001, 16'sd0, 16'sd0);
    push_command(16'sd0, 16'sd0, 16'sd32767);

    // zero limit: anything nonzero collapses to zero and is flagged
    apply_settings(16'd0, 16'd256, 16'd0, 1'b0);
    push_command(16'sd0, 16'sd0, 16'sd0);
    push_command(16'sd1, 16'sd0, 16'sd0);
    push_command(-16'sd32768, 16'sd0, 16'sd0);

    // all ones written: lever and limit keep only their own widths
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_command(16'sd32767, 16'sd32767, 16'sd32767);
    push_command(-16'sd32768, -16'sd32768, 16'sd32767);
    push_command(16'sd32767, -16'sd32768, -16'sd32768);
    push_command(-16'sd1, -16'sd1, -16'sd1);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: lv = 16'd0;
        1: lv = 16'hFFFF;
        default: lv = CFG_DATA_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: gn = 16'd0;
        1: gn = 16'hFFFF;
        2: gn = 16'd256;
        default: gn = CFG_DATA_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: lm = 16'd0;
        1: lm = 16'h7FFF;
        2: lm = 16'hFFFF;
        default: lm = CFG_DATA_W'($urandom);
      endcase
      if (ph == RANDOM_PHASES - 1) begin
        quiet = 1'b1;
      end
      apply_settings(lv, gn, lm, bit'($urandom_range(0, 1)));
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if (n == WORDS_PER_PHASE / 2) begin
          drain();
        end
        sender_gap();
        push_command(pick_speed(), pick_speed(), pick_speed());
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Covered %0d command words under %0d register settings", sent, settings);
    $display("%0d results compared, %0d of them desaturated", checked, scaled_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
